// ===== rtl/mcpg_pkg.sv =====
// Shared types, constants and point tables for the midpoint circle point generator.
// No dependencies; every other file in rtl/ refers to this package by scoped name.
package mcpg_pkg;

  // Default coordinate width of the centre fields.
  localparam int COORD_BITS_DEF = 8;
  // Default depth of the step queue between the front and back ends.
  localparam int QDEPTH_DEF     = 2;

  localparam int RADIUS_W = 7;   // radius field width
  localparam int OFS_W    = 9;   // signed working width of the a/b offsets
  localparam int DEC_W    = 12;  // signed width of the decision term
  localparam int PT_W     = 3;   // point index within a step
  localparam int NUM_PTS  = 8;   // points per step

  // Opcodes of the input item.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // Decision-term constants.
  localparam logic signed [DEC_W-1:0] DEC_INIT  = DEC_W'(3);
  localparam logic signed [DEC_W-1:0] DEC_NEG   = DEC_W'(6);
  localparam logic signed [DEC_W-1:0] DEC_POS   = DEC_W'(10);

  // Non-coordinate part of one queued step.
  typedef struct packed {
    logic [RADIUS_W-1:0] a;
    logic [RADIUS_W-1:0] b;
    logic                on;
    logic                done;
  } job_t;

  // How each of the eight points is built from (a, b).
  typedef struct packed {
    logic swap;   // x takes b, y takes a
    logic neg_x;
    logic neg_y;
  } pt_sel_t;

  // Point order: (a,b) (b,a) (-a,b) (b,-a) (-a,-b) (-b,-a) (a,-b) (-b,a)
  localparam pt_sel_t PT_TAB [NUM_PTS] = '{
    '{swap: 1'b0, neg_x: 1'b0, neg_y: 1'b0},
    '{swap: 1'b1, neg_x: 1'b0, neg_y: 1'b0},
    '{swap: 1'b0, neg_x: 1'b1, neg_y: 1'b0},
    '{swap: 1'b1, neg_x: 1'b0, neg_y: 1'b1},
    '{swap: 1'b0, neg_x: 1'b1, neg_y: 1'b1},
    '{swap: 1'b1, neg_x: 1'b1, neg_y: 1'b1},
    '{swap: 1'b0, neg_x: 1'b0, neg_y: 1'b1},
    '{swap: 1'b1, neg_x: 1'b1, neg_y: 1'b0}
  };

  localparam logic [PT_W-1:0] PT_LAST = PT_W'(NUM_PTS - 1);

endpackage

// ===== rtl/mcpg_if.sv =====
// Valid/ready channel interfaces for the circle point generator (input and output).
// Depends on mcpg_pkg for field widths.
interface mcpg_in_if #(
  parameter int COORD_BITS = mcpg_pkg::COORD_BITS_DEF
);
  logic                                 valid;
  logic                                 ready;
  logic                                 opcode;
  logic signed [COORD_BITS-1:0]         center_x;
  logic signed [COORD_BITS-1:0]         center_y;
  logic        [mcpg_pkg::RADIUS_W-1:0] radius;
  logic                                 pixel_on;

  modport source (output valid, opcode, center_x, center_y, radius, pixel_on, input ready);
  modport sink   (input valid, opcode, center_x, center_y, radius, pixel_on, output ready);
endinterface

interface mcpg_out_if #(
  parameter int COORD_BITS = mcpg_pkg::COORD_BITS_DEF
);
  logic                       valid;
  logic                       ready;
  logic signed [COORD_BITS:0] point_x;
  logic signed [COORD_BITS:0] point_y;
  logic                       point_on;
  logic                       last_of_step;
  logic                       circle_done;

  modport source (output valid, point_x, point_y, point_on, last_of_step, circle_done,
                  input ready);
  modport sink   (input valid, point_x, point_y, point_on, last_of_step, circle_done,
                  output ready);
endinterface

// ===== rtl/mcpg_queue.sv =====
// Small FIFO of step jobs between the front and back ends.
// Depends on mcpg_pkg for its default depth.
module mcpg_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = mcpg_pkg::QDEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic [DATA_W-1:0] head,
  output logic              full,
  output logic              empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule

// ===== rtl/mcpg_front.sv =====
// Front end: accepts load and step items, runs the midpoint recurrence, queues step jobs.
// Depends on mcpg_pkg and mcpg_in_if.
module mcpg_front #(
  parameter int COORD_BITS = mcpg_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  mcpg_in_if.sink                      in_ch,
  input  logic                         q_full,
  output logic                         q_push,
  output logic signed [COORD_BITS-1:0] job_cx,
  output logic signed [COORD_BITS-1:0] job_cy,
  output mcpg_pkg::job_t               job
);
  localparam int OW = mcpg_pkg::OFS_W;
  localparam int DW = mcpg_pkg::DEC_W;
  localparam int RW = mcpg_pkg::RADIUS_W;

  logic signed [COORD_BITS-1:0] cx;
  logic signed [COORD_BITS-1:0] cy;
  logic signed [OW-1:0]         a;
  logic signed [OW-1:0]         b;
  logic signed [DW-1:0]         d;
  logic                         on;
  logic                         busy;

  logic signed [OW-1:0] a_next;
  logic signed [OW-1:0] b_next;
  logic signed [DW-1:0] d_next;
  logic signed [DW-1:0] a_w;
  logic signed [DW-1:0] b_w;
  logic                 done;
  logic                 fire;

  assign in_ch.ready = !q_full;
  assign fire        = in_ch.valid && in_ch.ready;

  always_comb begin
    a_w    = DW'(a);
    b_w    = DW'(b);
    a_next = a + OW'(1);
    if (d < 0) begin
      d_next = d + (a_w <<< 2) + mcpg_pkg::DEC_NEG;
      b_next = b;
    end else begin
      d_next = d + ((a_w - b_w) <<< 2) + mcpg_pkg::DEC_POS;
      b_next = b - OW'(1);
    end
    done = (a_next > b_next);
  end

  // Queue only steps of an active circle; snapshot the offsets before the update.
  assign q_push   = fire && (in_ch.opcode == mcpg_pkg::OP_STEP) && busy;
  assign job_cx   = cx;
  assign job_cy   = cy;
  assign job.a    = a[RW-1:0];
  assign job.b    = b[RW-1:0];
  assign job.on   = on;
  assign job.done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      cx   <= '0;
      cy   <= '0;
      a    <= '0;
      b    <= '0;
      d    <= '0;
      on   <= 1'b0;
      busy <= 1'b0;
    end else if (fire) begin
      if (in_ch.opcode == mcpg_pkg::OP_LOAD) begin
        cx   <= in_ch.center_x;
        cy   <= in_ch.center_y;
        a    <= '0;
        b    <= OW'(in_ch.radius);
        d    <= mcpg_pkg::DEC_INIT - (DW'(in_ch.radius) <<< 1);
        on   <= in_ch.pixel_on;
        busy <= 1'b1;
      end else if (busy) begin
        a    <= a_next;
        b    <= b_next;
        d    <= d_next;
        busy <= !done;
      end
    end
  end
endmodule

// ===== rtl/mcpg_back.sv =====
// Back end: plays one queued step out as eight point beats on the output channel.
// Depends on mcpg_pkg and mcpg_out_if.
module mcpg_back #(
  parameter int COORD_BITS = mcpg_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_empty,
  input  logic signed [COORD_BITS-1:0] head_cx,
  input  logic signed [COORD_BITS-1:0] head_cy,
  input  mcpg_pkg::job_t               head_job,
  output logic                         q_pop,
  mcpg_out_if.source                   out_ch
);
  localparam int CW = COORD_BITS + 1;
  localparam int PW = mcpg_pkg::PT_W;

  logic                         job_valid;
  logic signed [COORD_BITS-1:0] cx;
  logic signed [COORD_BITS-1:0] cy;
  mcpg_pkg::job_t               job;
  logic [PW-1:0]                k;

  mcpg_pkg::pt_sel_t    sel;
  logic [CW-1:0]        ox;
  logic [CW-1:0]        oy;
  logic [CW-1:0]        cx_w;
  logic [CW-1:0]        cy_w;
  logic                 fire;
  logic                 is_last;
  logic                 free;

  assign fire    = out_ch.valid && out_ch.ready;
  assign is_last = (k == mcpg_pkg::PT_LAST);
  assign free    = !job_valid || (fire && is_last);
  assign q_pop   = free && !q_empty;

  always_comb begin
    sel  = mcpg_pkg::PT_TAB[k];
    ox   = sel.swap ? CW'(job.b) : CW'(job.a);
    oy   = sel.swap ? CW'(job.a) : CW'(job.b);
    cx_w = {cx[COORD_BITS-1], cx};
    cy_w = {cy[COORD_BITS-1], cy};
  end

  assign out_ch.valid        = job_valid;
  assign out_ch.point_x      = sel.neg_x ? (cx_w - ox) : (cx_w + ox);
  assign out_ch.point_y      = sel.neg_y ? (cy_w - oy) : (cy_w + oy);
  assign out_ch.point_on     = job.on;
  assign out_ch.last_of_step = is_last;
  assign out_ch.circle_done  = is_last && job.done;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cx  <= head_cx;
      cy  <= head_cy;
      job <= head_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      k         <= '0;
    end else begin
      if (free) begin
        job_valid <= !q_empty;
        k         <= '0;
      end else if (fire) begin
        k <= k + 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_idle_index_zero: assert property (@(posedge clk) disable iff (rst)
    !job_valid |-> (k == '0))
    else $error("point index advanced with no job loaded");

  a_stall_holds_index: assert property (@(posedge clk) disable iff (rst)
    (job_valid && !out_ch.ready) |=> (job_valid && $stable(k)))
    else $error("stalled step lost its job or point index");

  a_done_on_last: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.circle_done) |-> out_ch.last_of_step)
    else $error("circle_done outside the last point of a step");

  a_pop_when_free: assert property (@(posedge clk) disable iff (rst)
    (job_valid && !is_last && q_pop) |-> 1'b0)
    else $error("queue popped while a step is still playing out");
`endif
endmodule

// ===== rtl/midpoint_circle_point_generator_unit.sv =====
// Top level of the midpoint circle point generator: front end, step queue, back end.
// Depends on mcpg_pkg, mcpg_in_if/mcpg_out_if, mcpg_front, mcpg_queue and mcpg_back.
//
//   channel   dir   beat contents                                    per item
//   in_ch     in    opcode, center_x, center_y, radius, pixel_on      one beat
//   out_ch    out   point_x, point_y, point_on, last_of_step,         eight beats per
//                   circle_done                                       active step
//
// A load or a step is taken whenever the step queue has room; a load and a step of an
// idle circle give no output beats.
// Each queued step occupies the back end for eight beats, one point per beat; the next
// step is popped as its last beat is taken, so the single output channel sets the pace.
// Reset (rst, synchronous) drops any active circle and empties the queue.
// An output stall holds the current point; input keeps flowing until the queue fills.
module midpoint_circle_point_generator_unit #(
  parameter int COORD_BITS = mcpg_pkg::COORD_BITS_DEF,
  parameter int QDEPTH     = mcpg_pkg::QDEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  mcpg_in_if.sink     in_ch,
  mcpg_out_if.source  out_ch
);
  localparam int JOB_BITS = $bits(mcpg_pkg::job_t);
  localparam int DATA_W   = 2 * COORD_BITS + JOB_BITS;

  // Front-end snapshot of one step.
  logic                         q_push;
  logic signed [COORD_BITS-1:0] push_cx;
  logic signed [COORD_BITS-1:0] push_cy;
  mcpg_pkg::job_t               push_job;

  // Queue status and head.
  logic                         q_full;
  logic                         q_empty;
  logic                         q_pop;
  logic [DATA_W-1:0]            q_head;

  // Head fields as seen by the back end.
  logic signed [COORD_BITS-1:0] head_cx;
  logic signed [COORD_BITS-1:0] head_cy;
  mcpg_pkg::job_t               head_job;

  assign head_cx  = q_head[DATA_W-1 -: COORD_BITS];
  assign head_cy  = q_head[JOB_BITS +: COORD_BITS];
  assign head_job = q_head[JOB_BITS-1:0];

  // Classify items and advance the recurrence.
  mcpg_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .job_cx (push_cx),
    .job_cy (push_cy),
    .job    (push_job)
  );

  // Decouple item intake from point output.
  mcpg_queue #(
    .DATA_W (DATA_W),
    .DEPTH  (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data ({push_cx, push_cy, push_job}),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Emit the eight symmetric points of each step.
  mcpg_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .head_cx  (head_cx),
    .head_cy  (head_cy),
    .head_job (head_job),
    .q_pop    (q_pop),
    .out_ch   (out_ch)
  );
endmodule

// ===== bench/midpoint_circle_point_generator_unit_test.sv =====
`timescale 1ns / 100ps
// Self-checking bench for midpoint_circle_point_generator_unit: random valid/ready traffic,
// a circle-rasterizer predictor in a small scoreboard class, and point-by-point checks.
// Depends on mcpg_pkg, mcpg_in_if / mcpg_out_if and the RTL of the generator.
module midpoint_circle_point_generator_unit_test;

  localparam int CW          = mcpg_pkg::COORD_BITS_DEF;
  localparam int RW          = mcpg_pkg::RADIUS_W;
  localparam int ITEM_TARGET = 370;
  // Stop idling on both channels once this many items have gone in.
  localparam int CALM_AFTER  = 300;
  // Worst case is far below this: ~400 items, 8 beats each, every beat held by the longest ready drop.
  localparam int RUN_LIMIT_NS = 2_000_000;

  // One input beat as seen on in_ch.
  typedef struct packed {
    logic                  opcode;
    logic signed [CW-1:0]  cx;
    logic signed [CW-1:0]  cy;
    logic [RW-1:0]         radius;
    logic                  on;
  } circle_cmd_t;

  // One output beat as seen on out_ch.
  typedef struct packed {
    logic signed [CW:0] x;
    logic signed [CW:0] y;
    logic               on;
    logic               last;
    logic               done;
  } point_t;

  // Tracks the rasterizer state and keeps the points it still owes, oldest first.
  class circle_scoreboard;
    logic signed [CW-1:0] centre_col = '0;
    logic signed [CW-1:0] centre_row = '0;
    int                   ofs_a;
    int                   ofs_b;
    int                   decision;
    logic                 colour = 1'b0;
    bit                   active;
    point_t               point_fifo[$];
    int                   errors;
    int                   loads;
    int                   steps;
    int                   live_steps;
    int                   points_seen;
    int                   circles_done;

    function int pending();
      return point_fifo.size();
    endfunction

    // Advance the predictor by one accepted command and queue the points it causes.
    function void note_cmd(circle_cmd_t c);
      int     dx[8];
      int     dy[8];
      int     a;
      int     b;
      bit     fin;
      point_t pt;
      if (c.opcode == mcpg_pkg::OP_LOAD) begin
        loads++;
        centre_col = c.cx;
        centre_row = c.cy;
        colour     = c.on;
        ofs_a      = 0;
        ofs_b      = int'(c.radius);
        decision   = 3 - 2 * ofs_b;
        active     = 1'b1;
        return;
      end
      steps++;
      if (!active)
        return;
      live_steps++;
      a  = ofs_a;
      b  = ofs_b;
      dx = '{a, b, -a, b, -a, -b, a, -b};
      dy = '{b, a, b, -a, -b, -a, -b, a};
      if (decision < 0) begin
        decision += 4 * a + 6;
      end else begin
        decision += 4 * (a - b) + 10;
        b -= 1;
      end
      a += 1;
      ofs_a = a;
      ofs_b = b;
      fin = (a > b);
      if (fin)
        active = 1'b0;
      for (int k = 0; k < mcpg_pkg::NUM_PTS; k++) begin
        pt.x    = (CW + 1)'(int'(centre_col) + dx[k]);
        pt.y    = (CW + 1)'(int'(centre_row) + dy[k]);
        pt.on   = colour;
        pt.last = (k == mcpg_pkg::NUM_PTS - 1);
        pt.done = (k == mcpg_pkg::NUM_PTS - 1) && fin;
        point_fifo.push_back(pt);
      end
    endfunction

    function void report(string field, int want, int got);
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endfunction

    // Compare one accepted point with the oldest owed one.
    function void check_point(point_t got);
      point_t want;
      if (point_fifo.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected point, expected none, got x=%0d y=%0d", $time,
                 got.x, got.y);
        return;
      end
      want = point_fifo.pop_front();
      points_seen++;
      if (got.x !== want.x)       report("point_x", want.x, got.x);
      if (got.y !== want.y)       report("point_y", want.y, got.y);
      if (got.on !== want.on)     report("point_on", want.on, got.on);
      if (got.last !== want.last) report("last_of_step", want.last, got.last);
      if (got.done !== want.done) report("circle_done", want.done, got.done);
      if (want.done)
        circles_done++;
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   idle_en = 1'b1;   // cleared for calm stretches and for the tail of the run
  int   items_sent;

  circle_scoreboard sb = new;

  mcpg_in_if  #(.COORD_BITS(CW)) in_ch ();
  mcpg_out_if #(.COORD_BITS(CW)) out_ch ();

  midpoint_circle_point_generator_unit dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #RUN_LIMIT_NS;
    $display("Timeout at %0t ns with %0d points still owed", $time, sb.pending());
    $display("Verification failed");
    $finish;
  end

  // Monitor both channels at the edge. Note input beats first; a step's points pass through
  // the queue and the back-end job register, so they always come after their command.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_cmd('{in_ch.opcode, in_ch.center_x, in_ch.center_y, in_ch.radius,
                      in_ch.pixel_on});
      if (out_ch.valid && out_ch.ready)
        sb.check_point('{out_ch.point_x, out_ch.point_y, out_ch.point_on,
                         out_ch.last_of_step, out_ch.circle_done});
    end
  end

  // Output back-pressure: drop ready in random bursts while idling is on.
  initial begin
    out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (idle_en && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Present one beat, optionally after a random gap, and hold it until it is taken.
  task automatic send_cmd(input logic op, input logic signed [CW-1:0] cx,
                          input logic signed [CW-1:0] cy, input logic [RW-1:0] r,
                          input logic on);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.opcode   <= op;
    in_ch.center_x <= cx;
    in_ch.center_y <= cy;
    in_ch.radius   <= r;
    in_ch.pixel_on <= on;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic load_circle(input logic signed [CW-1:0] cx, input logic signed [CW-1:0] cy,
                             input logic [RW-1:0] r, input logic on);
    send_cmd(mcpg_pkg::OP_LOAD, cx, cy, r, on);
  endtask

  // Step with junk in the unused fields; they must have no effect.
  task automatic step_circle(input int count);
    repeat (count)
      send_cmd(mcpg_pkg::OP_STEP, CW'($urandom), CW'($urandom), RW'($urandom),
               1'($urandom));
  endtask

  // Mostly small circles so that many finish; now and then a large one.
  function automatic int pick_radius();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70)
      return $urandom_range(0, 15);
    else if (roll < 95)
      return $urandom_range(16, 60);
    else
      return $urandom_range(61, 127);
  endfunction

  initial begin
    int r;
    int nsteps;
    int roll;
    rst            <= 1'b1;
    in_ch.valid    <= 1'b0;
    in_ch.opcode   <= mcpg_pkg::OP_LOAD;
    in_ch.center_x <= '0;
    in_ch.center_y <= '0;
    in_ch.radius   <= '0;
    in_ch.pixel_on <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part.
    // Step straight out of reset: no circle is active, so nothing comes out.
    step_circle(1);
    // Zero radius: centre eight times, circle finished, then a dead step.
    load_circle(8'sd127, -8'sd128, 7'd0, 1'b1);
    step_circle(2);
    // Largest radius at the most negative column, dropped part way by a new load.
    load_circle(-8'sd128, 8'sd127, 7'd127, 1'b0);
    step_circle(3);
    load_circle(8'sd127, 8'sd127, 7'd127, 1'b1);
    step_circle(2);
    // Most negative corner with the largest radius.
    load_circle(-8'sd128, -8'sd128, 7'd127, 1'b1);
    step_circle(3);
    // Tiny circles run to completion plus an extra step.
    load_circle(8'sd0, 8'sd0, 7'd1, 1'b1);
    step_circle(2);
    load_circle(-8'sd5, 8'sd3, 7'd2, 1'b0);
    step_circle(3);

    // Random part: mostly whole circles with random content, some cut short by a fresh
    // load, plus a little noise.
    while (items_sent < ITEM_TARGET) begin
      idle_en = (items_sent < CALM_AFTER) && ($urandom_range(0, 4) != 0);
      roll    = $urandom_range(0, 99);
      if (roll < 10) begin
        send_cmd(1'($urandom), CW'($urandom), CW'($urandom), RW'($urandom),
                 1'($urandom));
      end else begin
        r = pick_radius();
        load_circle(CW'($urandom), CW'($urandom), RW'(r), 1'($urandom));
        // Mostly enough steps to finish any circle of this radius; else possibly too few.
        nsteps = (roll < 85) ? (r * 3) / 4 + 2 : $urandom_range(0, (r * 3) / 4);
        // Hold the total near the target.
        if (nsteps > ITEM_TARGET - items_sent)
          nsteps = ITEM_TARGET - items_sent;
        step_circle(nsteps);
      end
    end
    in_ch.valid <= 1'b0;
    idle_en = 1'b0;

    // Drain, then give the block time to show any stray beat.
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (24) @(posedge clk);

    $display("Run covered %0d loads and %0d steps (%0d on a live circle), %0d beats in.",
             sb.loads, sb.steps, sb.live_steps, items_sent);
    $display("Checked %0d points, %0d circles finished, %0d mismatches.",
             sb.points_seen, sb.circles_done, sb.errors);
    if (sb.errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/mcpg_pkg.sv
rtl/mcpg_if.sv
rtl/mcpg_queue.sv
rtl/mcpg_front.sv
rtl/mcpg_back.sv
rtl/midpoint_circle_point_generator_unit.sv
bench/midpoint_circle_point_generator_unit_test.sv
